@@ rtl/core/csg_pkg.sv @@
// Shared widths, codes and control bundles of the candlestick segment generator.
package csg_pkg;

    localparam int BAR_W    = 16;
    localparam int PRICE_W  = 32;
    localparam int ROWS_W   = 13;
    localparam int SCROLL_W = 24;
    localparam int PITCH_W  = 16;
    localparam int GLYPH_W  = 6;
    localparam int X_W      = 32;
    localparam int Y_W      = 24;
    localparam int CLS_W    = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = BAR_W + 4 * PRICE_W;
    localparam int OUT_TDATA_W = 2 * X_W + 2 * Y_W;

    // bar position in Q.8, wide enough for pitch product minus scroll plus column offset
    localparam int PX_W     = BAR_W + PITCH_W + 3;
    // |price - floor| * rows
    localparam int PROD_W   = PRICE_W + ROWS_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS + 1);
    localparam int ROWX_W   = PROD_W + 2;
    localparam int RIDX_W   = 2;

    localparam logic [GLYPH_W-1:0] MAX_GLYPH_WIDTH = GLYPH_W'(63);
    localparam logic [PRICE_W-1:0] PRICE_MIN_RAW   = PRICE_W'(410);
    localparam logic signed [PRICE_W:0] FLAT_LIMIT     = (PRICE_W + 1)'(37);
    localparam logic signed [PRICE_W:0] FLAT_LIMIT_NEG = -FLAT_LIMIT;

    localparam logic signed [PX_W-1:0] X_HI = PX_W'(64'sd2147483647);
    localparam logic signed [PX_W-1:0] X_LO = PX_W'(-64'sd2147483648);
    localparam logic signed [ROWX_W-1:0] Y_HI = ROWX_W'(64'sd8388607);
    localparam logic signed [ROWX_W-1:0] Y_LO = ROWX_W'(-64'sd8388608);

    // register reset values
    localparam logic [PRICE_W-1:0]  RST_FLOOR  = PRICE_W'(0);
    localparam logic [PRICE_W-1:0]  RST_CEIL   = PRICE_W'(409600);
    localparam logic [ROWS_W-1:0]   RST_ROWS   = ROWS_W'(480);
    localparam logic [SCROLL_W-1:0] RST_SCROLL = SCROLL_W'(0);
    localparam logic [PITCH_W-1:0]  RST_PITCH  = PITCH_W'(2048);
    localparam logic [GLYPH_W-1:0]  RST_WIDTH  = GLYPH_W'(5);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CEIL   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 3'd5;

    // colour classes
    localparam logic [CLS_W-1:0] CLS_RISE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_FALL = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FLAT = 2'd2;

    // projected rows, in the order the controller works them
    localparam logic [RIDX_W-1:0] ROW_LOW   = 2'd0;
    localparam logic [RIDX_W-1:0] ROW_HIGH  = 2'd1;
    localparam logic [RIDX_W-1:0] ROW_CLOSE = 2'd2;
    localparam logic [RIDX_W-1:0] ROW_OPEN  = 2'd3;

    typedef struct packed {
        logic              load;       // latch the bar word
        logic              prep;       // clamp and offset one price
        logic              div_start;  // multiply by rows, start the divider
        logic              row_store;  // finish one row
        logic              emit_wick;
        logic              emit_body;  // flat line or one body column
        logic [RIDX_W-1:0] row_idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic wick_last;
        logic flat;
        logic body_last;
    } stat_t;

endpackage

@@ rtl/core/candlestick_segment_generator_top.sv @@
// Top level of the candlestick segment generator: stream ports, controller and datapath.
// Sequence: once a bar word is taken, four row projections run (prep, multiply, 45-step
//   restoring divider, store) before the first segment word is valid.
// Throughput: each bar yields n segments, n = segment count (1 to 63); one segment per
//   cycle when the output side does not stall, next bar taken only when idle.
// Reset: aresetn synchronous, active low; view registers to defaults, output word dropped.
module candlestick_segment_generator_top
    import csg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // register write port
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    // bar words in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] bar_number, [47:16] open_price, [79:48] high_price,
    // [111:80] low_price, [143:112] close_price
    input  logic [IN_TDATA_W-1:0]  s_tdata,

    // segment words out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] start_x, [55:32] start_y, [87:56] end_x, [111:88] end_y
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [1:0] colour_class
    output logic [CLS_W-1:0]       m_tuser,
    // final_segment: last segment of the bar
    output logic                   m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    logic [X_W-1:0] start_x, end_x;
    logic [Y_W-1:0] start_y, end_y;

    // Controller owns sequencing; it takes a bar only when idle. The last segment
    // of the previous bar may then still sit in the output register, and may stay
    // there through the row projections of the new bar.
    csg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: bar position (bar * pitch - scroll), class, row projection
    // through the shared divider, then one segment word per emit command.
    csg_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_bar      (s_tdata[BAR_W-1:0]),
        .in_open     (s_tdata[BAR_W +: PRICE_W]),
        .in_high     (s_tdata[BAR_W+PRICE_W +: PRICE_W]),
        .in_low      (s_tdata[BAR_W+2*PRICE_W +: PRICE_W]),
        .in_close    (s_tdata[BAR_W+3*PRICE_W +: PRICE_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_start_x (start_x),
        .out_start_y (start_y),
        .out_end_x   (end_x),
        .out_end_y   (end_y),
        .out_cls     (m_tuser),
        .out_last    (m_tlast)
    );

    assign m_tdata = {end_y, end_x, start_y, start_x};

endmodule

@@ rtl/core/csg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module csg_div
    import csg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PRICE_W-1:0] divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [PRICE_W-1:0] rem_reg, rem_next;
    logic [PRICE_W-1:0] div_reg;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [PRICE_W:0] shifted;
    logic [PRICE_W:0] trial;
    logic             ge;
    logic             busy;

    assign busy    = (cnt_reg != '0);
    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign ge      = (shifted >= {1'b0, div_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = DCNT_W'(DIV_STEPS);
        end else if (busy) begin
            rem_next  = ge ? trial[PRICE_W-1:0] : shifted[PRICE_W-1:0];
            quo_next  = {quo_reg[PROD_W-2:0], ge};
            cnt_next  = cnt_reg - DCNT_W'(1);
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/csg_datapath.sv @@
// Datapath: view registers, bar latch, row projection, segment build, output word.
module csg_datapath
    import csg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [BAR_W-1:0]      in_bar,
    input  logic [PRICE_W-1:0]    in_open,
    input  logic [PRICE_W-1:0]    in_high,
    input  logic [PRICE_W-1:0]    in_low,
    input  logic [PRICE_W-1:0]    in_close,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [X_W-1:0]        out_start_x,
    output logic [Y_W-1:0]        out_start_y,
    output logic [X_W-1:0]        out_end_x,
    output logic [Y_W-1:0]        out_end_y,
    output logic [CLS_W-1:0]      out_cls,
    output logic                  out_last
);

    localparam logic signed [ROWX_W-1:0] ROW_ONE = ROWX_W'(1);

    // view registers
    logic [PRICE_W-1:0]  floor_reg;
    logic [PRICE_W-1:0]  ceil_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [SCROLL_W-1:0] scroll_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [GLYPH_W-1:0]  width_reg;

    // bar state
    logic signed [PX_W-1:0] px_reg, px_next;
    logic [CLS_W-1:0]       cls_reg, cls_next;
    logic [PRICE_W-1:0]     price_reg [4];
    logic [Y_W-1:0]         row_reg [4];
    logic [PRICE_W-1:0]     mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [GLYPH_W-1:0]     j_reg, j_next;

    // output word
    logic               out_valid_reg, out_valid_next;
    logic [X_W-1:0]     sx_reg, sx_next, ex_reg, ex_next;
    logic [Y_W-1:0]     sy_reg, sy_next, ey_reg, ey_next;
    logic [CLS_W-1:0]   oc_reg, oc_next;
    logic               last_reg, last_next;

    logic [GLYPH_W-1:0]  w_eff;
    logic [1:0]          wick_c;
    logic [GLYPH_W-1:0]  j_last;
    logic                flat;

    logic [BAR_W+PITCH_W-1:0] bp_prod;
    logic signed [PRICE_W:0]  d_cls;
    logic [PRICE_W-1:0]       v_sel, v_clamp;
    logic [PRICE_W:0]         v_diff;

    logic [PROD_W-1:0]  dividend;
    logic [PRICE_W-1:0] den;
    logic               range_ok;
    logic               div_done;
    logic [PROD_W-1:0]  quotient;
    logic signed [ROWX_W-1:0] rows_x, q_x, row_raw;
    logic [Y_W-1:0]           row_sat;

    function automatic logic [X_W-1:0] sat_x(input logic signed [PX_W-1:0] v);
        logic [X_W-1:0] r;
        if (v > X_HI) begin
            r = X_HI[X_W-1:0];
        end else if (v < X_LO) begin
            r = X_LO[X_W-1:0];
        end else begin
            r = v[X_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PX_W-1:0] col_x(input logic signed [PX_W-1:0] px,
                                                     input logic [GLYPH_W-1:0] col);
        return px + $signed(PX_W'({col, 8'h00}));
    endfunction

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg  <= RST_FLOOR;
            ceil_reg   <= RST_CEIL;
            rows_reg   <= RST_ROWS;
            scroll_reg <= RST_SCROLL;
            pitch_reg  <= RST_PITCH;
            width_reg  <= RST_WIDTH;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FLOOR:  floor_reg  <= cfg_wdata[PRICE_W-1:0];
                CFG_CEIL:   ceil_reg   <= cfg_wdata[PRICE_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_wdata[ROWS_W-1:0];
                CFG_SCROLL: scroll_reg <= cfg_wdata[SCROLL_W-1:0];
                CFG_PITCH:  pitch_reg  <= cfg_wdata[PITCH_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[GLYPH_W-1:0];
                default: ;
            endcase
        end
    end

    // glyph geometry
    assign w_eff = (width_reg > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : width_reg;

    always_comb begin
        case (w_eff)
            GLYPH_W'(1): wick_c = 2'd0;
            GLYPH_W'(3): wick_c = 2'd1;
            GLYPH_W'(5): wick_c = 2'd2;
            default:     wick_c = 2'd3;
        endcase
    end

    // last body column, skipping the wick column when it is the rightmost one
    assign j_last = (w_eff - GLYPH_W'(1) == GLYPH_W'(wick_c)) ? w_eff - GLYPH_W'(2)
                                                              : w_eff - GLYPH_W'(1);
    assign flat   = (cls_reg == CLS_FLAT);

    // bar position and class
    assign bp_prod = (BAR_W+PITCH_W)'(in_bar) * (BAR_W+PITCH_W)'(pitch_reg);
    assign px_next = $signed({{(PX_W-BAR_W-PITCH_W){1'b0}}, bp_prod})
                   - $signed({{(PX_W-SCROLL_W){scroll_reg[SCROLL_W-1]}}, scroll_reg});
    assign d_cls   = $signed({1'b0, in_close}) - $signed({1'b0, in_open});

    always_comb begin
        if (d_cls >= FLAT_LIMIT) begin
            cls_next = CLS_RISE;
        end else if (d_cls <= FLAT_LIMIT_NEG) begin
            cls_next = CLS_FALL;
        end else begin
            cls_next = CLS_FLAT;
        end
    end

    // price clamp and offset from floor, sign and magnitude
    assign v_sel    = price_reg[cmd.row_idx];
    assign v_clamp  = (v_sel < PRICE_MIN_RAW) ? PRICE_MIN_RAW : v_sel;
    assign v_diff   = {1'b0, v_clamp} - {1'b0, floor_reg};
    assign neg_next = v_diff[PRICE_W];
    assign mag_next = neg_next ? (~v_diff[PRICE_W-1:0] + PRICE_W'(1)) : v_diff[PRICE_W-1:0];

    assign range_ok = (ceil_reg > floor_reg);
    assign den      = ceil_reg - floor_reg;
    assign dividend = PROD_W'(mag_reg) * PROD_W'(rows_reg);

    csg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (quotient)
    );

    // row = rows - 1 - signed offset, saturated
    assign rows_x  = $signed(ROWX_W'(rows_reg));
    assign q_x     = range_ok ? $signed(ROWX_W'(quotient)) : '0;
    assign row_raw = neg_reg ? (rows_x - ROW_ONE + q_x) : (rows_x - ROW_ONE - q_x);

    always_comb begin
        if (row_raw > Y_HI) begin
            row_sat = Y_HI[Y_W-1:0];
        end else if (row_raw < Y_LO) begin
            row_sat = Y_LO[Y_W-1:0];
        end else begin
            row_sat = row_raw[Y_W-1:0];
        end
    end

    // segment build
    always_comb begin
        j_next         = j_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        oc_next        = oc_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (cmd.load) begin
            j_next = '0;
        end
        if (cmd.emit_wick) begin
            sx_next        = sat_x(col_x(px_reg, GLYPH_W'(wick_c)));
            ex_next        = sx_next;
            sy_next        = row_reg[ROW_LOW];
            ey_next        = row_reg[ROW_HIGH];
            oc_next        = cls_reg;
            last_next      = stat.wick_last;
            out_valid_next = 1'b1;
        end else if (cmd.emit_body) begin
            oc_next        = cls_reg;
            out_valid_next = 1'b1;
            if (flat) begin
                sx_next   = sat_x(px_reg);
                ex_next   = sat_x(col_x(px_reg, w_eff));
                sy_next   = row_reg[ROW_CLOSE];
                ey_next   = row_reg[ROW_CLOSE];
                last_next = 1'b1;
            end else begin
                sx_next   = sat_x(col_x(px_reg, j_reg));
                ex_next   = sx_next;
                sy_next   = row_reg[ROW_OPEN];
                ey_next   = row_reg[ROW_CLOSE];
                last_next = stat.body_last;
                j_next    = (j_reg + GLYPH_W'(1) == GLYPH_W'(wick_c)) ? j_reg + GLYPH_W'(2)
                                                                      : j_reg + GLYPH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load) begin
            px_reg               <= px_next;
            cls_reg              <= cls_next;
            price_reg[ROW_LOW]   <= in_low;
            price_reg[ROW_HIGH]  <= in_high;
            price_reg[ROW_CLOSE] <= in_close;
            price_reg[ROW_OPEN]  <= in_open;
        end
        if (cmd.prep) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (cmd.row_store) begin
            row_reg[cmd.row_idx] <= row_sat;
        end
        j_reg    <= j_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        oc_reg   <= oc_next;
        last_reg <= last_next;
    end

    assign stat.out_free  = ~out_valid_reg | out_ready;
    assign stat.div_done  = div_done;
    assign stat.wick_last = (w_eff == GLYPH_W'(1)) | (~flat & (w_eff == '0));
    assign stat.flat      = flat;
    assign stat.body_last = (j_reg == j_last);

    assign out_valid   = out_valid_reg;
    assign out_start_x = sx_reg;
    assign out_start_y = sy_reg;
    assign out_end_x   = ex_reg;
    assign out_end_y   = ey_reg;
    assign out_cls     = oc_reg;
    assign out_last    = last_reg;

endmodule

@@ rtl/core/csg_ctrl.sv @@
// Controller: sequences bar load, four row projections and segment emission.
module csg_ctrl
    import csg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_WICK,
        ST_BODY
    } state_t;

    state_t            state_reg, state_next;
    logic [RIDX_W-1:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.row_idx = idx_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = ROW_LOW;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    cmd.row_store = 1'b1;
                    if (idx_reg == ROW_OPEN) begin
                        state_next = ST_WICK;
                    end else begin
                        idx_next   = idx_reg + RIDX_W'(1);
                        state_next = ST_PREP;
                    end
                end
            end
            ST_WICK: begin
                if (stat.out_free) begin
                    cmd.emit_wick = 1'b1;
                    state_next    = stat.wick_last ? ST_IDLE : ST_BODY;
                end
            end
            ST_BODY: begin
                if (stat.out_free) begin
                    cmd.emit_body = 1'b1;
                    if (stat.flat || stat.body_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= ROW_LOW;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ tb/tb.sv @@
// Self-checking stream testbench for the candlestick segment generator.
`timescale 1ns / 1ps

module tb
    import csg_pkg::*;
();

    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RAND_PHASES    = 12;
    localparam int BARS_PER_PHASE = 27;

    localparam longint MIN_PRICE_RAW = 410;
    localparam longint FLAT_RAW      = 37;
    localparam longint WIDTH_CAP     = 63;
    localparam longint ROW_HI        = 8388607;
    localparam longint ROW_LO        = -8388608;
    localparam longint COL_HI        = 2147483647;
    localparam longint COL_LO        = -64'sd2147483648;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_HICCUP} rx_mode_t;

    typedef struct packed {
        logic [X_W-1:0]   sx;
        logic [Y_W-1:0]   sy;
        logic [X_W-1:0]   ex;
        logic [Y_W-1:0]   ey;
        logic [CLS_W-1:0] cls;
        logic             last;
    } seg_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [CLS_W-1:0]       m_tuser;
    logic                   m_tlast;

    // shadow of the view registers, starts at the reset values
    logic [PRICE_W-1:0]  floor_q  = 32'd0;
    logic [PRICE_W-1:0]  ceil_q   = 32'd409600;
    logic [ROWS_W-1:0]   rows_q   = 13'd480;
    logic [SCROLL_W-1:0] scroll_q = 24'd0;
    logic [PITCH_W-1:0]  pitch_q  = 16'd2048;
    logic [GLYPH_W-1:0]  width_q  = 6'd5;

    logic [IN_TDATA_W-1:0] bar_feed[$];
    seg_t                  segs_due[$];

    logic     bar_took    = 1'b0;
    int       burst_left  = 1;
    int       gap_left    = 0;
    rx_mode_t ready_mode  = RX_OPEN;
    int       ready_span  = 0;
    int       ready_tick  = 0;
    int       err_count   = 0;
    int       bars_taken  = 0;
    int       segs_checked = 0;
    int       cycles      = 0;

    candlestick_segment_generator_top i_dut (
        .aclk,
        .aresetn,
        .cfg_we,
        .cfg_addr,
        .cfg_wdata,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tuser,
        .m_tlast
    );

    always #5 aclk = ~aclk;

    task automatic note_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            note_error($sformatf("segment %0d %s: got %h, want %h",
                                 segs_checked, name, got, want));
        end
    endtask

    // price to screen row: clamp, scale against the view, saturate to 24 bits
    function automatic logic [Y_W-1:0] price_row(input logic [PRICE_W-1:0] p);
        longint v, off, row;
        v = longint'(p);
        if (v < MIN_PRICE_RAW) v = MIN_PRICE_RAW;
        off = 0;
        if (ceil_q > floor_q) begin
            off = ((v - longint'(floor_q)) * longint'(rows_q))
                  / (longint'(ceil_q) - longint'(floor_q));
        end
        row = longint'(rows_q) - 1 - off;
        if (row > ROW_HI) row = ROW_HI;
        else if (row < ROW_LO) row = ROW_LO;
        return row[Y_W-1:0];
    endfunction

    function automatic logic [X_W-1:0] col_word(input longint x);
        if (x > COL_HI) x = COL_HI;
        else if (x < COL_LO) x = COL_LO;
        return x[X_W-1:0];
    endfunction

    function automatic seg_t make_seg(input longint x0, input logic [Y_W-1:0] y0,
                                      input longint x1, input logic [Y_W-1:0] y1,
                                      input logic [CLS_W-1:0] cls);
        seg_t s;
        s.sx   = col_word(x0);
        s.sy   = y0;
        s.ex   = col_word(x1);
        s.ey   = y1;
        s.cls  = cls;
        s.last = 1'b0;
        return s;
    endfunction

    // queue up every segment one bar word should produce, wick first
    function automatic void segments_of_bar(input logic [IN_TDATA_W-1:0] word);
        seg_t               segs [64];
        logic [PRICE_W-1:0] open_p, high_p, low_p, close_p;
        logic [CLS_W-1:0]   cls;
        logic [Y_W-1:0]     y_open, y_close;
        longint             pos, w, wick, dlt;
        int                 n;
        open_p  = word[BAR_W +: PRICE_W];
        high_p  = word[BAR_W + PRICE_W +: PRICE_W];
        low_p   = word[BAR_W + 2 * PRICE_W +: PRICE_W];
        close_p = word[BAR_W + 3 * PRICE_W +: PRICE_W];
        pos = longint'(word[BAR_W-1:0]) * longint'(pitch_q) - longint'(signed'(scroll_q));
        w = longint'(width_q);
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        wick = (w == 1) ? 0 : (w == 3) ? 1 : (w == 5) ? 2 : 3;
        dlt = longint'(close_p) - longint'(open_p);
        if (dlt >= FLAT_RAW) cls = CLS_RISE;
        else if (dlt <= -FLAT_RAW) cls = CLS_FALL;
        else cls = CLS_FLAT;
        y_open  = price_row(open_p);
        y_close = price_row(close_p);
        segs[0] = make_seg(pos + wick * 256, price_row(low_p),
                           pos + wick * 256, price_row(high_p), cls);
        n = 1;
        if (w != 1) begin
            if (cls == CLS_FLAT) begin
                segs[n] = make_seg(pos, y_close, pos + w * 256, y_close, cls);
                n++;
            end else begin
                for (longint j = 0; j < w; j++) begin
                    if (j != wick) begin
                        segs[n] = make_seg(pos + j * 256, y_open, pos + j * 256, y_close, cls);
                        n++;
                    end
                end
            end
        end
        segs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) segs_due.push_back(segs[k]);
    endfunction

    // random price, mostly inside the current view, sometimes under the clamp
    function automatic logic [PRICE_W-1:0] view_price();
        longint span;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 800);
        if (ceil_q <= floor_q) return $urandom;
        span = longint'(ceil_q) - longint'(floor_q);
        return floor_q + 32'(longint'($urandom) % (span + 1));
    endfunction

    task automatic push_bar(input logic [BAR_W-1:0] bar, input logic [PRICE_W-1:0] o,
                            input logic [PRICE_W-1:0] h, input logic [PRICE_W-1:0] l,
                            input logic [PRICE_W-1:0] c);
        bar_feed.push_back({c, l, h, o, bar});
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FLOOR:  floor_q  = val;
            CFG_CEIL:   ceil_q   = val;
            CFG_ROWS:   rows_q   = val[ROWS_W-1:0];
            CFG_SCROLL: scroll_q = val[SCROLL_W-1:0];
            CFG_PITCH:  pitch_q  = val[PITCH_W-1:0];
            CFG_WIDTH:  width_q  = val[GLYPH_W-1:0];
            default: ;
        endcase
    endtask

    // polled on the rising edge, where feed, valid and the due list are settled
    task automatic wait_idle();
        do @(posedge aclk);
        while (bar_feed.size() != 0 || s_tvalid || segs_due.size() != 0);
    endtask

    // bar word driver: bursts of words, random gaps in between
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || bar_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (bar_feed.size() > 0) begin
                s_tdata  <= bar_feed.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 8);
                    // long gaps land anywhere in the projection pass
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 260)
                                                           : $urandom_range(0, 2);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // segment side backpressure, switches between stall patterns
    always @(negedge aclk) begin
        if (ready_span == 0) begin
            ready_mode = rx_mode_t'($urandom_range(0, 3));
            ready_span = $urandom_range(16, 200);
        end else begin
            ready_span--;
        end
        ready_tick++;
        case (ready_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            RX_SLOW: m_tready <= (ready_tick % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watches both channels: predicts on each bar word, checks each segment word
    always @(posedge aclk) begin : watch
        seg_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (segs_due.size() == 0) begin
                note_error($sformatf("segment word %h with nothing expected", m_tdata));
            end else begin
                want = segs_due.pop_front();
                check_field("start_x", m_tdata[31:0], want.sx);
                check_field("start_y", 32'(m_tdata[55:32]), 32'(want.sy));
                check_field("end_x", m_tdata[87:56], want.ex);
                check_field("end_y", 32'(m_tdata[111:88]), 32'(want.ey));
                check_field("colour_class", 32'(m_tuser), 32'(want.cls));
                check_field("final_segment", 32'(m_tlast), 32'(want.last));
                segs_checked++;
            end
        end
        bar_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            segments_of_bar(s_tdata);
            bars_taken++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d segments still due", cycles,
                     segs_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0]     floor_v, ceil_v, rows_v, scroll_v, pitch_v, width_v;
        logic [31:0]     open_v, close_v, high_v, low_v;
        logic [15:0]     bar_v;
        int              pick, kind, delta;
        int unsigned     row_marks[4]   = '{0, 1, 4096, 8191};
        int unsigned     width_marks[6] = '{0, 1, 2, 3, 5, 63};

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset view: class thresholds, price clamp, field extremes
        push_bar(16'd0, 40960, 61440, 20480, 81920);
        push_bar(16'd1, 81920, 90000, 30000, 40960);
        push_bar(16'd2, 50000, 50000, 50000, 50000);
        push_bar(16'd3, 100000, 100100, 99900, 100037);
        push_bar(16'd4, 100000, 100100, 99900, 100036);
        push_bar(16'd5, 100000, 100100, 99900, 99963);
        push_bar(16'd6, 100000, 100100, 99900, 99964);
        push_bar(16'hFFFF, 0, 409, 410, 411);
        push_bar(16'hFFFF, '1, '1, '1, '1);
        push_bar(16'h5555, 0, '1, 0, '1);
        push_bar(16'hAAAA, '1, '1, 0, 0);
        wait_idle();

        // glyph width corners: single column, wick outside body, zero width, wick as last column, widest
        write_reg(CFG_WIDTH, 32'd1);
        push_bar(16'd7, 40960, 61440, 20480, 81920);
        wait_idle();
        write_reg(CFG_WIDTH, 32'd2);
        push_bar(16'd8, 81920, 90000, 30000, 40960);
        wait_idle();
        write_reg(CFG_WIDTH, 32'd3);
        push_bar(16'd9, 50000, 60000, 40000, 50010);
        wait_idle();
        write_reg(CFG_WIDTH, 32'd0);
        push_bar(16'd10, 40960, 61440, 20480, 81920);
        push_bar(16'd11, 50000, 60000, 40000, 50000);
        wait_idle();
        write_reg(CFG_WIDTH, 32'd4);
        push_bar(16'd12, 40960, 61440, 20480, 81920);
        wait_idle();
        write_reg(CFG_WIDTH, 32'd63);
        push_bar(16'd13, 81920, 90000, 30000, 40960);
        wait_idle();
        write_reg(CFG_WIDTH, 32'd5);

        // empty price range (equal, then inverted), then zero rows
        write_reg(CFG_FLOOR, 32'd409600);
        push_bar(16'd14, 40960, 61440, 20480, 81920);
        wait_idle();
        write_reg(CFG_FLOOR, 32'd500000);
        push_bar(16'd15, 81920, 90000, 30000, 40960);
        wait_idle();
        write_reg(CFG_FLOOR, 32'd0);
        write_reg(CFG_ROWS, 32'd0);
        push_bar(16'd16, 40960, 61440, 20480, 81920);
        wait_idle();

        // rows pushed past the 24 bit range both ways
        write_reg(CFG_ROWS, 32'd8191);
        write_reg(CFG_FLOOR, 32'hFFFF_FFF0);
        write_reg(CFG_CEIL, 32'hFFFF_FFFF);
        push_bar(16'd17, 0, '1, 0, '1);
        wait_idle();
        write_reg(CFG_FLOOR, 32'd0);
        write_reg(CFG_CEIL, 32'd1);
        push_bar(16'd18, '1, '1, '1, '1);
        wait_idle();

        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);

        // x corners: scroll extremes, zero and full pitch, saturated columns
        write_reg(CFG_SCROLL, 32'h0080_0000);
        write_reg(CFG_PITCH, 32'd0);
        push_bar(16'd0, 40960, 61440, 20480, 81920);
        wait_idle();
        write_reg(CFG_SCROLL, 32'h007F_FFFF);
        write_reg(CFG_PITCH, 32'd1);
        push_bar(16'd0, 81920, 90000, 30000, 40960);
        wait_idle();
        write_reg(CFG_PITCH, 32'd65535);
        write_reg(CFG_WIDTH, 32'd63);
        push_bar(16'hFFFF, 40960, 61440, 20480, 81920);
        wait_idle();

        // random views; each phase drains fully, so the sender also sits idle
        // until every expected segment is back
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) floor_v = 0;
            else if (pick < 7) floor_v = $urandom_range(0, 1 << 22);
            else if (pick < 9) floor_v = $urandom;
            else floor_v = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            pick = $urandom_range(0, 9);
            if (pick < 6) ceil_v = floor_v + $urandom_range(1, 1 << 22);
            else if (pick < 8) ceil_v = $urandom;
            else if (pick == 8) ceil_v = floor_v;
            else ceil_v = 32'hFFFF_FFFF;

            rows_v = ($urandom_range(0, 4) == 0) ? row_marks[$urandom_range(0, 3)]
                                                 : $urandom_range(1, 1024);
            if ($urandom_range(0, 3) == 0) rows_v = rows_v | ($urandom << ROWS_W);

            pick = $urandom_range(0, 5);
            if (pick == 0) scroll_v = 32'h0080_0000;
            else if (pick == 1) scroll_v = 32'h007F_FFFF;
            else scroll_v = $urandom;

            pick = $urandom_range(0, 7);
            if (pick == 0) pitch_v = 1;
            else if (pick == 1) pitch_v = 65535;
            else if (pick == 2) pitch_v = 0;
            else pitch_v = $urandom_range(1, 4096);
            if ($urandom_range(0, 3) == 0) pitch_v = pitch_v | ($urandom << PITCH_W);

            pick = $urandom_range(0, 9);
            if (pick < 6) width_v = $urandom_range(0, 8);
            else if (pick < 9) width_v = width_marks[$urandom_range(0, 5)];
            else width_v = $urandom;

            write_reg(CFG_FLOOR, floor_v);
            write_reg(CFG_CEIL, ceil_v);
            write_reg(CFG_ROWS, rows_v);
            write_reg(CFG_SCROLL, scroll_v);
            write_reg(CFG_PITCH, pitch_v);
            write_reg(CFG_WIDTH, width_v);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
            end

            for (int k = 0; k < BARS_PER_PHASE; k++) begin
                bar_v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                                    : 16'($urandom);
                kind = $urandom_range(0, 7);
                if (kind == 0) begin
                    push_bar(bar_v, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    open_v = view_price();
                    if (kind < 4) begin
                        // close near open to work the flat band edges
                        delta = int'($urandom_range(0, 120)) - 60;
                        close_v = open_v + delta;
                    end else begin
                        close_v = view_price();
                    end
                    high_v = ((open_v > close_v) ? open_v : close_v) + $urandom_range(0, 500);
                    low_v  = ((open_v < close_v) ? open_v : close_v) - $urandom_range(0, 500);
                    push_bar(bar_v, open_v, high_v, low_v, close_v);
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (segs_due.size() != 0) begin
            note_error($sformatf("%0d segments never arrived", segs_due.size()));
        end

        $display("covered %0d bars over directed corners and %0d random views,", bars_taken,
                 RAND_PHASES);
        $display("%0d segment words checked, %0d mismatches", segs_checked, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/csg_pkg.sv
rtl/core/csg_div.sv
rtl/core/csg_datapath.sv
rtl/core/csg_ctrl.sv
rtl/core/candlestick_segment_generator_top.sv
tb/tb.sv
